FILE: rtl/gbs_pkg.sv
package gbs_pkg;

  // Store geometry
  localparam int MAX_BOXES = 256;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int MAX_KEPT  = 64;
  localparam int KEPT_W    = 7;

  // Field widths
  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int CLASS_W = 8;
  localparam int THR_W   = 16;
  localparam int CFG_W   = 16;
  localparam int OUT_IDX_W = 8;

  // Arithmetic widths of the overlap test
  localparam int EDGE_W  = COORD_W + 1;
  localparam int INTER_W = 2 * EDGE_W;
  localparam int AREA_W  = 2 * COORD_W;
  localparam int HALF_W  = INTER_W / 2;
  localparam int PART_W  = THR_W + HALF_W;
  localparam int PROD_W  = THR_W + INTER_W;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_IOU_THRESHOLD  = 2'd0,
    CFG_CLASS_AGNOSTIC = 2'd1,
    CFG_DET_LIMIT      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] cls;
  } box_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEL_INIT,
    OP_SEL_STEP,
    OP_KEEP,
    OP_SUP_INIT,
    OP_SUP_RD,
    OP_SUP_GEOM,
    OP_SUP_INTER,
    OP_SUP_AREA,
    OP_SUP_UNION,
    OP_SUP_PLO,
    OP_SUP_PHI,
    OP_SUP_DECIDE,
    OP_EMIT_PREV,
    OP_EMIT_LAST,
    OP_EMIT_NONE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic sel_done;
    logic found;
    logic pending;
    logic out_free;
    logic last_keep;
  } sts_t;

endpackage

FILE: rtl/greedy_box_suppression_top.sv
// Greedy box suppression.
// Box channel: box_valid / box_stall carry one box per request. Boxes are
// stored in load order, one per cycle while the block is loading; boxes
// beyond the store depth of 256 are dropped. The request with final_box set
// stores its box and starts the suppression pass, and box_stall stays high
// until the last result of the set has entered the output register.
// Result channel: kept_valid / kept_stall carry the kept boxes in descending
// score order, equal scores by lower load index, at most the configured
// detection limit of them; end_of_list marks the last one. A set with
// nothing kept gives one result with none_kept set.
// Pass: each kept box costs one selection scan over the store's single read
// port, then, unless it reaches the detection limit, a suppression scan of
// every stored box through the shared overlap unit.
// Configuration: cfg_valid / cfg_ready write one register per request; the
// port is always ready and is to be written only while the block is idle;
// the block itself does not enforce this.
// Reset: synchronous; empties the store, drops any waiting result and loads
// the register defaults. A stalled result holds in the output register.
module greedy_box_suppression_top
  import gbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 box_valid,
  output logic                 box_stall,
  input  logic [COORD_W-1:0]   box_left,
  input  logic [COORD_W-1:0]   box_top,
  input  logic [COORD_W-1:0]   box_width,
  input  logic [COORD_W-1:0]   box_height,
  input  logic [SCORE_W-1:0]   box_score,
  input  logic [CLASS_W-1:0]   box_class,
  input  logic                 final_box,
  output logic                 kept_valid,
  input  logic                 kept_stall,
  output logic [OUT_IDX_W-1:0] kept_index,
  output logic [SCORE_W-1:0]   kept_score,
  output logic [CLASS_W-1:0]   kept_class,
  output logic                 none_kept,
  output logic                 end_of_list,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;
  box_t in_box;

  assign cfg_ready = 1'b1;

  // Gather the box fields
  assign in_box = '{left: box_left, top: box_top, width: box_width,
                    height: box_height, score: box_score, cls: box_class};

  gbs_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .box_valid (box_valid),
    .final_box (final_box),
    .box_stall (box_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_box      (in_box),
    .in_final    (final_box),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kept_valid  (kept_valid),
    .kept_stall  (kept_stall),
    .kept_index  (kept_index),
    .kept_score  (kept_score),
    .kept_class  (kept_class),
    .none_kept   (none_kept),
    .end_of_list (end_of_list)
  );

endmodule

FILE: rtl/gbs_datapath.sv
module gbs_datapath
  import gbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  box_t                 in_box,
  input  logic                 in_final,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 kept_valid,
  input  logic                 kept_stall,
  output logic [OUT_IDX_W-1:0] kept_index,
  output logic [SCORE_W-1:0]   kept_score,
  output logic [CLASS_W-1:0]   kept_class,
  output logic                 none_kept,
  output logic                 end_of_list
);

  // Box store, one entry per load index
  box_t mem [MAX_BOXES];
  box_t rd_box;

  logic [THR_W-1:0]   iou_threshold;
  logic               class_agnostic;
  logic [KEPT_W-1:0]  det_max;
  logic [KEPT_W-1:0]  limit;

  logic [CNT_W-1:0]   loaded_count;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   rd_idx;
  logic               rd_valid;
  logic [MAX_BOXES-1:0] done;

  logic               best_found;
  logic [IDX_W-1:0]   best_idx;
  box_t               best;

  logic               have_pending;
  logic [IDX_W-1:0]   pend_idx;
  logic [SCORE_W-1:0] pend_score;
  logic [CLASS_W-1:0] pend_class;
  logic [KEPT_W-1:0]  kept_cnt;

  logic [EDGE_W-1:0]  ov_w;
  logic [EDGE_W-1:0]  ov_h;
  logic               cand;
  logic [INTER_W-1:0] inter;
  logic [AREA_W-1:0]  area_a;
  logic [AREA_W-1:0]  area_b;
  logic [INTER_W-1:0] uni;
  logic [PART_W-1:0]  p_lo;
  logic [PART_W-1:0]  p_hi;

  logic               in_range;
  logic               rd_en;
  logic               out_load;
  logic [EDGE_W-1:0]  ax2, ay2, bx2, by2, x1, y1, x2, y2;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  lhs;

  assign in_range = idx < loaded_count;
  assign rd_en    = (cmd.op == OP_SEL_STEP && in_range) || cmd.op == OP_SUP_RD;
  assign out_load = cmd.op == OP_EMIT_PREV || cmd.op == OP_EMIT_LAST ||
                    cmd.op == OP_EMIT_NONE;

  // Detection limit: zero acts as one, large values saturate
  always_comb begin
    if (det_max == '0) begin
      limit = KEPT_W'(1);
    end else if (det_max > KEPT_W'(MAX_KEPT)) begin
      limit = KEPT_W'(MAX_KEPT);
    end else begin
      limit = det_max;
    end
  end

  // Status back to the controller
  assign sts.scan_end  = !in_range;
  assign sts.sel_done  = !in_range && !rd_valid;
  assign sts.found     = best_found;
  assign sts.pending   = have_pending;
  assign sts.out_free  = !kept_valid || !kept_stall;
  assign sts.last_keep = (kept_cnt + KEPT_W'(1)) == limit;

  // Overlap geometry between the held best box and the box just read
  always_comb begin
    ax2 = {1'b0, best.left} + {1'b0, best.width};
    ay2 = {1'b0, best.top} + {1'b0, best.height};
    bx2 = {1'b0, rd_box.left} + {1'b0, rd_box.width};
    by2 = {1'b0, rd_box.top} + {1'b0, rd_box.height};
    x1  = (best.left > rd_box.left) ? {1'b0, best.left} : {1'b0, rd_box.left};
    y1  = (best.top > rd_box.top) ? {1'b0, best.top} : {1'b0, rd_box.top};
    x2  = (ax2 < bx2) ? ax2 : bx2;
    y2  = (ay2 < by2) ? ay2 : by2;
    prod = {{(PROD_W-PART_W){1'b0}}, p_lo} +
           {p_hi, {HALF_W{1'b0}}};
    lhs  = {inter, {THR_W{1'b0}}};
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold  <= THR_W'(29491);
      class_agnostic <= 1'b0;
      det_max        <= KEPT_W'(64);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IOU_THRESHOLD:  iou_threshold  <= cfg_data[THR_W-1:0];
        CFG_CLASS_AGNOSTIC: class_agnostic <= cfg_data[0];
        CFG_DET_LIMIT:      det_max        <= cfg_data[KEPT_W-1:0];
        default: ;
      endcase
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && !loaded_count[CNT_W-1]) begin
      mem[loaded_count[IDX_W-1:0]] <= in_box;
    end
    if (rd_en) begin
      rd_box <= mem[idx[IDX_W-1:0]];
    end
  end

  // Control state of the pass
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      idx          <= '0;
      rd_valid     <= 1'b0;
      done         <= '0;
      best_found   <= 1'b0;
      have_pending <= 1'b0;
      kept_cnt     <= '0;
    end else begin
      rd_valid <= (cmd.op == OP_SEL_STEP) && in_range;
      unique case (cmd.op)
        OP_LOAD: begin
          if (!loaded_count[CNT_W-1]) begin
            loaded_count <= loaded_count + CNT_W'(1);
          end
          if (in_final) begin
            done         <= '0;
            have_pending <= 1'b0;
            kept_cnt     <= '0;
          end
        end
        OP_SEL_INIT: begin
          idx        <= '0;
          best_found <= 1'b0;
        end
        OP_SEL_STEP: begin
          if (in_range) begin
            idx <= idx + CNT_W'(1);
          end
          // Strictly greater keeps the lower index on equal scores
          if (rd_valid && !done[rd_idx[IDX_W-1:0]] &&
              (!best_found || rd_box.score > best.score)) begin
            best_found <= 1'b1;
          end
        end
        OP_KEEP: begin
          done[best_idx] <= 1'b1;
          have_pending   <= 1'b1;
          kept_cnt       <= kept_cnt + KEPT_W'(1);
        end
        OP_SUP_INIT: idx <= '0;
        OP_SUP_DECIDE: begin
          if (cand && lhs > prod) begin
            done[idx[IDX_W-1:0]] <= 1'b1;
          end
          idx <= idx + CNT_W'(1);
        end
        OP_EMIT_LAST, OP_EMIT_NONE: loaded_count <= '0;
        default: ;
      endcase
    end
  end

  // Payload registers of the pass
  always_ff @(posedge clk) begin
    rd_idx <= idx;
    if (cmd.op == OP_SEL_STEP && rd_valid && !done[rd_idx[IDX_W-1:0]] &&
        (!best_found || rd_box.score > best.score)) begin
      best     <= rd_box;
      best_idx <= rd_idx[IDX_W-1:0];
    end
    unique case (cmd.op)
      OP_KEEP: begin
        pend_idx   <= best_idx;
        pend_score <= best.score;
        pend_class <= best.cls;
        area_a     <= best.width * best.height;
      end
      OP_SUP_GEOM: begin
        ov_w <= (x2 > x1) ? x2 - x1 : '0;
        ov_h <= (y2 > y1) ? y2 - y1 : '0;
        cand <= !done[idx[IDX_W-1:0]] &&
                (class_agnostic || best.cls == rd_box.cls);
      end
      OP_SUP_INTER: inter <= ov_w * ov_h;
      OP_SUP_AREA:  area_b <= rd_box.width * rd_box.height;
      OP_SUP_UNION: begin
        uni <= {{(INTER_W-AREA_W){1'b0}}, area_a} +
               {{(INTER_W-AREA_W){1'b0}}, area_b} - inter;
      end
      OP_SUP_PLO: p_lo <= iou_threshold * uni[HALF_W-1:0];
      OP_SUP_PHI: p_hi <= iou_threshold * uni[INTER_W-1:HALF_W];
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_valid <= 1'b0;
    end else if (out_load) begin
      kept_valid <= 1'b1;
    end else if (!kept_stall) begin
      kept_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd.op == OP_EMIT_NONE) begin
        kept_index <= '0;
        kept_score <= '0;
        kept_class <= '0;
        none_kept  <= 1'b1;
      end else begin
        kept_index <= OUT_IDX_W'(pend_idx);
        kept_score <= pend_score;
        kept_class <= pend_class;
        none_kept  <= 1'b0;
      end
      end_of_list <= cmd.op != OP_EMIT_PREV;
    end
  end

endmodule

FILE: rtl/gbs_controller.sv
module gbs_controller
  import gbs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic box_valid,
  input  logic final_box,
  output logic box_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEL_INIT,
    S_SEL,
    S_EMIT_PREV,
    S_KEEP,
    S_SUP_INIT,
    S_SUP_RD,
    S_SUP_GEOM,
    S_SUP_INTER,
    S_SUP_AREA,
    S_SUP_UNION,
    S_SUP_PLO,
    S_SUP_PHI,
    S_SUP_DECIDE,
    S_EMIT_LAST,
    S_EMIT_NONE
  } state_t;

  state_t state;
  state_t state_next;

  assign box_stall = state != S_IDLE;

  // Operation and next state
  always_comb begin
    cmd.op     = OP_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (box_valid) begin
          cmd.op = OP_LOAD;
          if (final_box) begin
            state_next = S_SEL_INIT;
          end
        end
      end
      S_SEL_INIT: begin
        cmd.op     = OP_SEL_INIT;
        state_next = S_SEL;
      end
      S_SEL: begin
        cmd.op = OP_SEL_STEP;
        if (sts.sel_done) begin
          priority if (sts.found && sts.pending) begin
            state_next = S_EMIT_PREV;
          end else if (sts.found) begin
            state_next = S_KEEP;
          end else if (sts.pending) begin
            state_next = S_EMIT_LAST;
          end else begin
            state_next = S_EMIT_NONE;
          end
        end
      end
      S_EMIT_PREV: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_PREV;
          state_next = S_KEEP;
        end
      end
      S_KEEP: begin
        cmd.op     = OP_KEEP;
        state_next = sts.last_keep ? S_EMIT_LAST : S_SUP_INIT;
      end
      S_SUP_INIT: begin
        cmd.op     = OP_SUP_INIT;
        state_next = S_SUP_RD;
      end
      S_SUP_RD: begin
        if (sts.scan_end) begin
          state_next = S_SEL_INIT;
        end else begin
          cmd.op     = OP_SUP_RD;
          state_next = S_SUP_GEOM;
        end
      end
      S_SUP_GEOM: begin
        cmd.op     = OP_SUP_GEOM;
        state_next = S_SUP_INTER;
      end
      S_SUP_INTER: begin
        cmd.op     = OP_SUP_INTER;
        state_next = S_SUP_AREA;
      end
      S_SUP_AREA: begin
        cmd.op     = OP_SUP_AREA;
        state_next = S_SUP_UNION;
      end
      S_SUP_UNION: begin
        cmd.op     = OP_SUP_UNION;
        state_next = S_SUP_PLO;
      end
      S_SUP_PLO: begin
        cmd.op     = OP_SUP_PLO;
        state_next = S_SUP_PHI;
      end
      S_SUP_PHI: begin
        cmd.op     = OP_SUP_PHI;
        state_next = S_SUP_DECIDE;
      end
      S_SUP_DECIDE: begin
        cmd.op     = OP_SUP_DECIDE;
        state_next = S_SUP_RD;
      end
      S_EMIT_LAST: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_LAST;
          state_next = S_IDLE;
        end
      end
      S_EMIT_NONE: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_NONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/gbs_checker.sv
module gbs_checker
  import gbs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 box_valid,
  input logic                 box_stall,
  input logic                 final_box,
  input logic                 kept_valid,
  input logic                 kept_stall,
  input logic [OUT_IDX_W-1:0] kept_index,
  input logic [SCORE_W-1:0]   kept_score,
  input logic                 none_kept,
  input logic                 end_of_list
);

  // An empty set is always a single closing result.
  a_none_closes: assert property (@(posedge clk) disable iff (rst)
    kept_valid && none_kept |-> end_of_list)
    else $error("none_kept result without end_of_list");

  // The empty result carries zero fields.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    kept_valid && none_kept |-> kept_index == '0 && kept_score == '0)
    else $error("none_kept result with nonzero fields");

  // The last box of a set stops further loading while the pass runs.
  a_final_stalls: assert property (@(posedge clk) disable iff (rst)
    box_valid && !box_stall && final_box |=> box_stall)
    else $error("box channel open right after the last box");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    kept_valid && kept_stall |=> kept_valid && $stable(kept_index) &&
    $stable(end_of_list))
    else $error("stalled result changed");

endmodule

bind greedy_box_suppression_top gbs_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .box_valid   (box_valid),
  .box_stall   (box_stall),
  .final_box   (final_box),
  .kept_valid  (kept_valid),
  .kept_stall  (kept_stall),
  .kept_index  (kept_index),
  .kept_score  (kept_score),
  .none_kept   (none_kept),
  .end_of_list (end_of_list)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gbs_pkg::*;

  // One expected kept box
  typedef struct {
    logic [OUT_IDX_W-1:0] idx;
    logic [SCORE_W-1:0]   score;
    logic [CLASS_W-1:0]   cls;
    logic                 none;
    logic                 eol;
  } kept_box_t;

  // Scoreboard: mirrors the box store and runs greedy suppression on each set.
  class nms_scoreboard;
    box_t            boxes[MAX_BOXES];
    int unsigned     n_loaded;
    int unsigned     rank[MAX_BOXES];
    bit              gone[MAX_BOXES];
    logic [THR_W-1:0] thr;
    bit              agnostic;
    logic [KEPT_W-1:0] max_det;
    kept_box_t       kept_q[$];
    int              errors;
    int              n_results;
    int              n_sets;

    function new();
      thr = 16'd29491;
      agnostic = 0;
      max_det = KEPT_W'(64);
      n_loaded = 0;
      errors = 0;
      n_results = 0;
      n_sets = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_IOU_THRESHOLD: thr = val;
        CFG_CLASS_AGNOSTIC: agnostic = val[0];
        CFG_DET_LIMIT: max_det = val[KEPT_W-1:0];
        default: ;
      endcase
    endfunction

    // Box b is visited ahead of box a.
    function bit ranks_ahead(int unsigned b, int unsigned a);
      if (boxes[b].score != boxes[a].score) return boxes[b].score > boxes[a].score;
      return b < a;
    endfunction

    // Exact cross-multiplied overlap test.
    function bit too_close(int unsigned a, int unsigned b);
      longint unsigned ax2, ay2, bx2, by2, x1, y1, x2, y2, w, h, inter, uni;
      ax2 = longint'(boxes[a].left) + boxes[a].width;
      ay2 = longint'(boxes[a].top) + boxes[a].height;
      bx2 = longint'(boxes[b].left) + boxes[b].width;
      by2 = longint'(boxes[b].top) + boxes[b].height;
      x1 = boxes[a].left > boxes[b].left ? boxes[a].left : boxes[b].left;
      y1 = boxes[a].top > boxes[b].top ? boxes[a].top : boxes[b].top;
      x2 = ax2 < bx2 ? ax2 : bx2;
      y2 = ay2 < by2 ? ay2 : by2;
      w = x2 > x1 ? x2 - x1 : 0;
      h = y2 > y1 ? y2 - y1 : 0;
      inter = w * h;
      uni = longint'(boxes[a].width) * boxes[a].height +
            longint'(boxes[b].width) * boxes[b].height - inter;
      return (inter << 16) > longint'(thr) * uni;
    endfunction

    // Notes an accepted box; the final box of a set yields the kept list.
    function void note_box(box_t b, bit last);
      int unsigned i, j, cur, limit, kept, bi, bj;
      kept_box_t e;
      if (n_loaded < MAX_BOXES) begin
        boxes[n_loaded] = b;
        n_loaded++;
      end
      if (!last) return;
      n_sets++;
      limit = (max_det == 0) ? 1 : max_det;
      if (limit > MAX_KEPT) limit = MAX_KEPT;
      for (i = 0; i < n_loaded; i++) begin
        cur = i;
        j = i;
        while (j > 0 && ranks_ahead(cur, rank[j-1])) begin
          rank[j] = rank[j-1];
          j--;
        end
        rank[j] = cur;
        gone[i] = 0;
      end
      kept = 0;
      for (i = 0; i < n_loaded && kept < limit; i++) begin
        bi = rank[i];
        if (gone[bi]) continue;
        e.idx = bi[7:0];
        e.score = boxes[bi].score;
        e.cls = boxes[bi].cls;
        e.none = 0;
        e.eol = 0;
        kept_q = {kept_q, e};
        kept++;
        for (j = i + 1; j < n_loaded; j++) begin
          bj = rank[j];
          if (gone[bj]) continue;
          if (!agnostic && boxes[bi].cls != boxes[bj].cls) continue;
          if (too_close(bi, bj)) gone[bj] = 1;
        end
      end
      n_loaded = 0;
      if (kept == 0) begin
        e = '{idx: '0, score: '0, cls: '0, none: 1'b1, eol: 1'b1};
        kept_q = {kept_q, e};
      end else begin
        kept_q[$].eol = 1;
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(kept_box_t got);
      kept_box_t want;
      n_results++;
      if (kept_q.size() == 0) begin
        report($sformatf("unexpected result index %0d", got.idx));
        return;
      end
      want = kept_q.pop_front();
      if (got.idx !== want.idx)
        report($sformatf("kept_index %0d, expected %0d", got.idx, want.idx));
      if (got.score !== want.score)
        report($sformatf("kept_score %0h, expected %0h", got.score, want.score));
      if (got.cls !== want.cls)
        report($sformatf("kept_class %0d, expected %0d", got.cls, want.cls));
      if (got.none !== want.none)
        report($sformatf("none_kept %0b, expected %0b", got.none, want.none));
      if (got.eol !== want.eol)
        report($sformatf("end_of_list %0b, expected %0b", got.eol, want.eol));
    endtask
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 box_valid = 0;
  logic                 box_stall;
  logic [COORD_W-1:0]   box_left = 0, box_top = 0, box_width = 0, box_height = 0;
  logic [SCORE_W-1:0]   box_score = 0;
  logic [CLASS_W-1:0]   box_class = 0;
  logic                 final_box = 0;
  logic                 kept_valid;
  logic                 kept_stall = 0;
  logic [OUT_IDX_W-1:0] kept_index;
  logic [SCORE_W-1:0]   kept_score;
  logic [CLASS_W-1:0]   kept_class;
  logic                 none_kept;
  logic                 end_of_list;
  logic                 cfg_valid = 0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = 0;
  logic [CFG_W-1:0]     cfg_data = 0;

  nms_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;
  int boxes_sent = 0;

  always #5 clk = ~clk;

  greedy_box_suppression_top i_dut (
    .clk(clk), .rst(rst),
    .box_valid(box_valid), .box_stall(box_stall),
    .box_left(box_left), .box_top(box_top), .box_width(box_width),
    .box_height(box_height), .box_score(box_score), .box_class(box_class),
    .final_box(final_box),
    .kept_valid(kept_valid), .kept_stall(kept_stall),
    .kept_index(kept_index), .kept_score(kept_score), .kept_class(kept_class),
    .none_kept(none_kept), .end_of_list(end_of_list),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Result side stall: random, or a long counted hold-off when asked for.
  always @(negedge clk) begin
    static int hold_left = 0;
    static int holds_seen = 0;
    if (holds_seen != hold_requests) begin
      holds_seen = hold_requests;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      kept_stall <= 1'b1;
    end else begin
      kept_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Observe both channels at the rising edge.
  always @(posedge clk) begin
    box_t b;
    kept_box_t r;
    if (!rst) begin
      if (box_valid && !box_stall) begin
        b = '{left: box_left, top: box_top, width: box_width, height: box_height,
              score: box_score, cls: box_class};
        sb.note_box(b, final_box);
      end
      if (kept_valid && !kept_stall) begin
        r = '{idx: kept_index, score: kept_score, cls: kept_class,
              none: none_kept, eol: end_of_list};
        sb.check_result(r);
      end
    end
  end

  task write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offers one box request and waits until it is taken.
  task send_box(box_t b, bit last);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      box_valid <= 1'b0;
      @(negedge clk);
    end
    box_valid <= 1'b1;
    box_left <= b.left;
    box_top <= b.top;
    box_width <= b.width;
    box_height <= b.height;
    box_score <= b.score;
    box_class <= b.cls;
    final_box <= last;
    do @(posedge clk); while (box_stall);
    boxes_sent++;
    @(negedge clk);
    box_valid <= 1'b0;
  endtask

  // Waits until every kept box of the open sets has come out.
  task drain;
    while (sb.kept_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function box_t any_box();
    box_t b;
    b.left = COORD_W'($urandom);
    b.top = COORD_W'($urandom);
    b.width = COORD_W'($urandom);
    b.height = COORD_W'($urandom);
    b.score = SCORE_W'($urandom);
    b.cls = CLASS_W'($urandom);
    return b;
  endfunction

  // Boxes clustered around one center so that overlaps are common.
  task random_set(int n);
    box_t b;
    int cx, cy;
    cx = $urandom_range(60000);
    cy = $urandom_range(60000);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        b = any_box();
      end else begin
        b.left = COORD_W'(cx + $urandom_range(300));
        b.top = COORD_W'(cy + $urandom_range(300));
        b.width = COORD_W'(200 + $urandom_range(400));
        b.height = COORD_W'(200 + $urandom_range(400));
        b.score = $urandom_range(3) == 0 ? 16'($urandom_range(3) * 16384) : 16'($urandom);
        b.cls = CLASS_W'($urandom_range(2));
      end
      send_box(b, i == n - 1);
    end
  endtask

  task directed_part;
    box_t b;
    // Single box at the far corner with full extents.
    b = '{left: 16'hFFFF, top: 16'hFFFF, width: 16'hFFFF, height: 16'hFFFF,
          score: 16'hFFFF, cls: 8'hFF};
    send_box(b, 1);
    drain();
    // Identical boxes with tied scores, zero-area boxes and a distant one.
    b = '{left: 100, top: 100, width: 400, height: 400, score: 16'h8000, cls: 3};
    send_box(b, 0);
    send_box(b, 0);
    b.cls = 4;
    send_box(b, 0);
    b = '{left: 0, top: 0, width: 0, height: 0, score: 0, cls: 0};
    send_box(b, 0);
    b = '{left: 0, top: 0, width: 0, height: 0, score: 16'h8000, cls: 3};
    send_box(b, 0);
    b = '{left: 40000, top: 40000, width: 10, height: 10, score: 16'h8001, cls: 3};
    send_box(b, 0);
    // Half-overlapping pair: ratio exactly one third.
    b = '{left: 1000, top: 1000, width: 200, height: 100, score: 16'h4000, cls: 3};
    send_box(b, 0);
    b = '{left: 1100, top: 1000, width: 200, height: 100, score: 16'h3FFF, cls: 3};
    send_box(b, 1);
    drain();
    write_reg(CFG_IOU_THRESHOLD, 16'd21845);
    write_reg(CFG_CLASS_AGNOSTIC, 1);
    b = '{left: 1000, top: 1000, width: 200, height: 100, score: 16'h4000, cls: 1};
    send_box(b, 0);
    b = '{left: 1100, top: 1000, width: 200, height: 100, score: 16'h4000, cls: 2};
    send_box(b, 0);
    b = '{left: 1050, top: 1000, width: 200, height: 100, score: 16'h0001, cls: 9};
    send_box(b, 1);
    drain();
  endtask

  // Stimulus
  initial begin
    logic [CFG_W-1:0] thr_pick[4];
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_part();

    thr_pick = '{16'd0, 16'hFFFF, 16'd29491, 16'd13107};
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = phase == 0 ? 37 : phase == 1 ? 57 : 0;
      rx_idle_pct = phase == 0 ? 57 : phase == 1 ? 37 : 0;
      for (int s = 0; s < 4; s++) begin
        write_reg(CFG_IOU_THRESHOLD, s == 3 ? 16'($urandom) : thr_pick[s]);
        write_reg(CFG_CLASS_AGNOSTIC, CFG_W'($urandom_range(1)));
        case ($urandom_range(4))
          0: write_reg(CFG_DET_LIMIT, 1);
          1: write_reg(CFG_DET_LIMIT, 0);
          2: write_reg(CFG_DET_LIMIT, 127);
          default: write_reg(CFG_DET_LIMIT, 64);
        endcase
        if (phase == 1 && s == 1) hold_requests++;
        for (int k = 0; k < 3; k++) random_set($urandom_range(1, 8));
        // Pause the sender until the open sets are all out.
        drain();
      end
    end

    write_reg(CFG_DET_LIMIT, 64);
    random_set(6);
    drain();
    repeat (200) @(posedge clk);

    $display("Sent %0d boxes in %0d sets and checked %0d kept results.",
             boxes_sent, sb.n_sets, sb.n_results);
    $display("Covered thresholds at both ends, both class modes and the detection limits.");
    if (sb.errors == 0 && sb.kept_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("Mismatches %0d, results still owed %0d.", sb.errors, sb.kept_q.size());
      $display("status: fail");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #50ms;
    $display("Timed out with %0d results still owed.", sb.kept_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/gbs_pkg.sv
rtl/gbs_datapath.sv
rtl/gbs_controller.sv
rtl/greedy_box_suppression_top.sv
rtl/gbs_checker.sv
sim/tb_top.sv
